@@ sv/stg_pkg.sv @@
// Package for the sinusoid trajectory generator: sizes, register indexes,
// datapath command type and the constant quarter-wave sine table.
// No dependencies; every other file of the block refers to it by scoped names.
`default_nettype none

package stg_pkg;

  localparam int TABLE_BITS = 10;
  localparam int TABLE_LEN  = 1 << TABLE_BITS;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ANGULAR_RATE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AMP_FIRST     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_AMP_SECOND    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_FIRST   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_SECOND  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_FIRST  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_SECOND = 3'd7;

  localparam logic [31:0] RST_PHASE_STEP   = 32'd4294967;
  localparam logic [31:0] RST_ANGULAR_RATE = 32'd411775;
  localparam logic [15:0] RST_AMP          = 16'd6554;

  localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;
  localparam logic [31:0] ONE_Q30     = 32'd1073741824;
  localparam logic [5:0][7:0] SERIES_DIV = {8'd6, 8'd20, 8'd42, 8'd72, 8'd110, 8'd156};

  typedef logic [TABLE_LEN-1:0][15:0] sine_tab_t;

  // Entry i is sin(pi/2*(i+1/2)/TABLE_LEN) in Q15, from a nested series
  function automatic sine_tab_t build_sine_table();
    sine_tab_t   tab;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    tab = '0;
    for (int i = 0; i < TABLE_LEN; i++) begin
      x  = (64'(HALF_PI_Q30) * 64'(2 * i + 1) + (64'd1 << TABLE_BITS)) >> (TABLE_BITS + 1);
      x2 = (x * x) >> 30;
      t  = 64'(ONE_Q30);
      for (int j = 0; j < 6; j++) begin
        t = 64'(ONE_Q30) - (((x2 * t) >> 30) / 64'(SERIES_DIV[j]));
      end
      s = (x * t) >> 30;
      s = (s + 64'd16384) >> 15;
      if (s > 64'd32767) begin
        s = 64'd32767;
      end
      tab[i] = s[15:0];
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TABLE = build_sine_table();

  // Datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_NONE,
    OP_START,
    OP_RD_SIN,
    OP_RD_COS,
    OP_MUL_AW,
    OP_MUL_POS,
    OP_MUL_AWW,
    OP_MUL_VEL,
    OP_MUL_ACC_LO,
    OP_MUL_ACC_HI,
    OP_FINISH
  } op_t;

  typedef struct packed {
    op_t  op;
    logic ax;       // 0: first axis, 1: second axis
    logic restart;  // valid with OP_START
  } cmd_t;

endpackage

`default_nettype wire

@@ sv/sinusoid_trajectory_generator_top.sv @@
// Sinusoid trajectory generator: two-axis sine/cosine setpoints per tick.
// Each tick runs both axes in turn through the single shared 32x32 multiplier
// (six passes per axis) and one ROM port; in_stall holds off the next tick.
// Reset: synchronous active-low; phase accumulator to zero, registers to defaults.
// The sine table is a constant ROM, so no clearing pass follows reset.
// Depends on stg_pkg, stg_ctrl and stg_datapath.
`default_nettype none

module sinusoid_trajectory_generator_top (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic                           in_restart,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic signed [31:0]                  out_pos_first,
  output logic signed [31:0]                  out_pos_second,
  output logic signed [31:0]                  out_vel_first,
  output logic signed [31:0]                  out_vel_second,
  output logic signed [31:0]                  out_acc_first,
  output logic signed [31:0]                  out_acc_second,
  input  wire logic                           cfg_we,
  input  wire logic [stg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [stg_pkg::CFG_DATA_W-1:0] cfg_data
);

  stg_pkg::cmd_t cmd;

  stg_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_restart (in_restart),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .cmd        (cmd)
  );

  stg_datapath u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .out_pos_first  (out_pos_first),
    .out_pos_second (out_pos_second),
    .out_vel_first  (out_vel_first),
    .out_vel_second (out_vel_second),
    .out_acc_first  (out_acc_first),
    .out_acc_second (out_acc_second)
  );

`ifndef SYNTH
  a_finish_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == stg_pkg::OP_FINISH) |-> (!out_valid || !out_stall))
    else $error("result written while output transaction still pending");

  a_finish_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == stg_pkg::OP_FINISH) |=> out_valid)
    else $error("finished tick did not raise out_valid");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (in_stall && cmd.op == stg_pkg::OP_RD_SIN && !cmd.ax))
    else $error("accepted tick did not start with the first axis sine read");

  a_axis_order: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == stg_pkg::OP_MUL_ACC_HI && !cmd.ax) |=>
      (cmd.op == stg_pkg::OP_RD_SIN && cmd.ax))
    else $error("second axis did not follow the first");
`endif

endmodule

`default_nettype wire

@@ sv/stg_ctrl.sv @@
// Controller of the sinusoid trajectory generator: sequences table reads and
// shared multiplier passes for both axes, and owns the input/output handshake.
// Depends on stg_pkg.
`default_nettype none

module stg_ctrl (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_stall,
  input  wire logic         in_restart,
  output logic              out_valid,
  input  wire logic         out_stall,
  output stg_pkg::cmd_t     cmd
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_SIN,
    ST_RD_COS,
    ST_MUL_AW,
    ST_MUL_POS,
    ST_MUL_AWW,
    ST_MUL_VEL,
    ST_MUL_ACC_LO,
    ST_MUL_ACC_HI,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   ax_r;
  logic   ax_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;
  logic   out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    ax_nxt        = ax_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd.op        = stg_pkg::OP_NONE;
    cmd.ax        = ax_r;
    cmd.restart   = in_restart;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.op    = stg_pkg::OP_START;
          ax_nxt    = 1'b0;
          state_nxt = ST_RD_SIN;
        end
      end
      ST_RD_SIN: begin
        cmd.op    = stg_pkg::OP_RD_SIN;
        state_nxt = ST_RD_COS;
      end
      ST_RD_COS: begin
        cmd.op    = stg_pkg::OP_RD_COS;
        state_nxt = ST_MUL_AW;
      end
      ST_MUL_AW: begin
        cmd.op    = stg_pkg::OP_MUL_AW;
        state_nxt = ST_MUL_POS;
      end
      ST_MUL_POS: begin
        cmd.op    = stg_pkg::OP_MUL_POS;
        state_nxt = ST_MUL_AWW;
      end
      ST_MUL_AWW: begin
        cmd.op    = stg_pkg::OP_MUL_AWW;
        state_nxt = ST_MUL_VEL;
      end
      ST_MUL_VEL: begin
        cmd.op    = stg_pkg::OP_MUL_VEL;
        state_nxt = ST_MUL_ACC_LO;
      end
      ST_MUL_ACC_LO: begin
        cmd.op    = stg_pkg::OP_MUL_ACC_LO;
        state_nxt = ST_MUL_ACC_HI;
      end
      ST_MUL_ACC_HI: begin
        cmd.op = stg_pkg::OP_MUL_ACC_HI;
        if (!ax_r) begin
          ax_nxt    = 1'b1;
          state_nxt = ST_RD_SIN;
        end else begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // let the last write-back land
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        // hold until the output register can take the transaction
        if (out_free) begin
          cmd.op        = stg_pkg::OP_FINISH;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ax_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ax_r        <= ax_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

@@ sv/stg_datapath.sv @@
// Datapath of the sinusoid trajectory generator: configuration registers,
// phase accumulator, sine table ROM, one shared 32x32 multiplier with a
// registered write-back stage, and the output register. Depends on stg_pkg.
`default_nettype none

module stg_datapath (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire stg_pkg::cmd_t                  cmd,
  input  wire logic                           cfg_we,
  input  wire logic [stg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [stg_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic signed [31:0]                  out_pos_first,
  output logic signed [31:0]                  out_pos_second,
  output logic signed [31:0]                  out_vel_first,
  output logic signed [31:0]                  out_vel_second,
  output logic signed [31:0]                  out_acc_first,
  output logic signed [31:0]                  out_acc_second
);

  // Configuration
  logic [31:0] phase_step_r;
  logic [31:0] angular_rate_r;
  logic [15:0] amp_first_r;
  logic [15:0] amp_second_r;
  logic [15:0] phase_first_r;
  logic [15:0] phase_second_r;
  logic [31:0] offset_first_r;
  logic [31:0] offset_second_r;

  logic [31:0] phase_r;

  // Table lookup
  logic [31:0]                     angle;
  logic [1:0]                      quad_s;
  logic [1:0]                      quad_c;
  logic [stg_pkg::TABLE_BITS-1:0]  tab_k;
  logic [stg_pkg::TABLE_BITS-1:0]  rom_addr;
  logic [15:0]                     rom_q_r;
  logic [15:0]                     sm_r;
  logic [15:0]                     cm_r;
  logic                            sn_r;
  logic                            cn_r;

  // Multiplier and write-back
  logic [15:0]  amp;
  logic [15:0]  pm;
  logic [15:0]  vm;
  logic [31:0]  mul_a;
  logic [31:0]  mul_b;
  logic [63:0]  mul_p;
  logic [63:0]  prod_r;
  stg_pkg::op_t wb_op_r;
  logic         wb_ax_r;
  logic         wb_pn;
  logic         wb_vn;
  logic [63:0]  acc_sum;
  logic [31:0]  aw_r;
  logic [47:0]  aww_r;
  logic [63:0]  acc_lo_r;
  logic [31:0]  pt_r  [2];
  logic [31:0]  vel_r [2];
  logic [31:0]  acc_r [2];

  function automatic logic [31:0] sat_mag(input logic [48:0] mag, input logic neg);
    logic [31:0] res;
    if (neg) begin
      res = (|mag[48:31]) ? 32'h8000_0000 : (32'd0 - mag[31:0]);
    end else begin
      res = (|mag[48:31]) ? 32'h7FFF_FFFF : mag[31:0];
    end
    return res;
  endfunction

  function automatic logic [31:0] sat_sum(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    logic [31:0] res;
    s = {a[31], a} + {b[31], b};
    if (s[32] != s[31]) begin
      res = s[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      res = s[31:0];
    end
    return res;
  endfunction

  // Angle of the axis in work; cosine reads one quadrant ahead
  assign angle    = phase_r + {(cmd.ax ? phase_second_r : phase_first_r), 16'd0};
  assign quad_s   = angle[31:30];
  assign quad_c   = quad_s + 2'd1;
  assign tab_k    = angle[29 -: stg_pkg::TABLE_BITS];
  assign rom_addr = (cmd.op == stg_pkg::OP_RD_COS) ? (quad_c[0] ? ~tab_k : tab_k)
                                                   : (quad_s[0] ? ~tab_k : tab_k);

  assign amp = cmd.ax ? amp_second_r : amp_first_r;
  assign pm  = cmd.ax ? cm_r : sm_r;
  assign vm  = cmd.ax ? sm_r : cm_r;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      stg_pkg::OP_MUL_AW: begin
        mul_a = {16'd0, amp};
        mul_b = angular_rate_r;
      end
      stg_pkg::OP_MUL_POS: begin
        mul_a = {16'd0, amp};
        mul_b = {16'd0, pm};
      end
      stg_pkg::OP_MUL_AWW: begin
        mul_a = aw_r;
        mul_b = angular_rate_r;
      end
      stg_pkg::OP_MUL_VEL: begin
        mul_a = aw_r;
        mul_b = {16'd0, vm};
      end
      stg_pkg::OP_MUL_ACC_LO: begin
        mul_a = aww_r[31:0];
        mul_b = {16'd0, pm};
      end
      stg_pkg::OP_MUL_ACC_HI: begin
        mul_a = {16'd0, aww_r[47:32]};
        mul_b = {16'd0, pm};
      end
      default: begin
      end
    endcase
  end

  assign mul_p   = mul_a * mul_b;
  assign wb_pn   = wb_ax_r ? cn_r : sn_r;
  assign wb_vn   = wb_ax_r ? ~sn_r : cn_r;
  assign acc_sum = {prod_r[31:0], 32'd0} + acc_lo_r;

  // Configuration registers and phase accumulator
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_step_r    <= stg_pkg::RST_PHASE_STEP;
      angular_rate_r  <= stg_pkg::RST_ANGULAR_RATE;
      amp_first_r     <= stg_pkg::RST_AMP;
      amp_second_r    <= stg_pkg::RST_AMP;
      phase_first_r   <= '0;
      phase_second_r  <= '0;
      offset_first_r  <= '0;
      offset_second_r <= '0;
      phase_r         <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          stg_pkg::REG_PHASE_STEP:    phase_step_r    <= cfg_data;
          stg_pkg::REG_ANGULAR_RATE:  angular_rate_r  <= cfg_data;
          stg_pkg::REG_AMP_FIRST:     amp_first_r     <= cfg_data[15:0];
          stg_pkg::REG_AMP_SECOND:    amp_second_r    <= cfg_data[15:0];
          stg_pkg::REG_PHASE_FIRST:   phase_first_r   <= cfg_data[15:0];
          stg_pkg::REG_PHASE_SECOND:  phase_second_r  <= cfg_data[15:0];
          stg_pkg::REG_OFFSET_FIRST:  offset_first_r  <= cfg_data;
          stg_pkg::REG_OFFSET_SECOND: offset_second_r <= cfg_data;
          default: begin
          end
        endcase
      end
      if (cmd.op == stg_pkg::OP_START && cmd.restart) begin
        phase_r <= '0;
      end else if (cmd.op == stg_pkg::OP_FINISH) begin
        phase_r <= phase_r + phase_step_r;
      end
    end
  end

  // Table ROM, sine/cosine capture, multiplier and write-back
  always_ff @(posedge clk) begin
    rom_q_r <= stg_pkg::SINE_TABLE[rom_addr];
    if (cmd.op == stg_pkg::OP_RD_COS) begin
      sm_r <= rom_q_r;
      sn_r <= quad_s[1];
    end
    if (cmd.op == stg_pkg::OP_MUL_AW) begin
      cm_r <= rom_q_r;
      cn_r <= quad_c[1];
    end
    prod_r  <= mul_p;
    wb_op_r <= cmd.op;
    wb_ax_r <= cmd.ax;
    case (wb_op_r)
      stg_pkg::OP_MUL_AW: begin
        aw_r <= 32'((prod_r + 64'd32768) >> 16);
      end
      stg_pkg::OP_MUL_AWW: begin
        aww_r <= 48'((prod_r + 64'd32768) >> 16);
      end
      stg_pkg::OP_MUL_POS: begin
        pt_r[wb_ax_r] <= sat_mag(49'((prod_r + 64'd16384) >> 15), wb_pn);
      end
      stg_pkg::OP_MUL_VEL: begin
        vel_r[wb_ax_r] <= sat_mag(49'((prod_r + 64'd16384) >> 15), wb_vn);
      end
      stg_pkg::OP_MUL_ACC_LO: begin
        // fold the rounding constant in now
        acc_lo_r <= prod_r + 64'd16384;
      end
      stg_pkg::OP_MUL_ACC_HI: begin
        acc_r[wb_ax_r] <= sat_mag(acc_sum[63:15], ~wb_pn);
      end
      default: begin
      end
    endcase
    if (cmd.op == stg_pkg::OP_FINISH) begin
      out_pos_first  <= sat_sum(offset_first_r, pt_r[0]);
      out_pos_second <= sat_sum(offset_second_r, pt_r[1]);
      out_vel_first  <= vel_r[0];
      out_vel_second <= vel_r[1];
      out_acc_first  <= acc_r[0];
      out_acc_second <= acc_r[1];
    end
  end

endmodule

`default_nettype wire
